FILE: rtl/mlfq_pkg.sv
// shared types, constants and codes for the multilevel feedback queue lock arbiter
`timescale 1ns / 1ps

package mlfq_pkg;

    localparam int MAX_THREADS = 16;
    localparam int NUM_LEVELS  = 8;

    localparam int TID_W   = 4;
    localparam int LVL_W   = 3;
    localparam int CNT_W   = 5;
    localparam int ADDR_W  = LVL_W + TID_W;
    localparam int HOLD_W  = 32;
    localparam int NLVL_W  = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [NLVL_W-1:0] LEVELS_RESET  = 4'd8;
    localparam logic [HOLD_W-1:0] QUANTUM_RESET = 32'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_TICKS = 1'd1;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [2:0] ST_ACQUIRED = 3'd0;
    localparam logic [2:0] ST_QUEUED   = 3'd1;
    localparam logic [2:0] ST_HANDED   = 3'd2;
    localparam logic [2:0] ST_FREED    = 3'd3;
    localparam logic [2:0] ST_ERROR    = 3'd4;

    typedef struct packed {
        logic              op;
        logic [TID_W-1:0]  thread_id;
        logic [HOLD_W-1:0] hold_ticks;
    } req_item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [TID_W-1:0] granted_thread;
        logic [LVL_W-1:0] level;
    } rsp_item_t;

endpackage

FILE: rtl/mlfq_lock_arbiter.sv
// top level of the multilevel feedback queue lock arbiter
`timescale 1ns / 1ps

// Lock arbiter with one FIFO of waiting threads per priority level. The block
// takes one request at a time and is not ready while it works on it. An
// acquire is decided in the ACQ state and its result leaves through DONE. A
// release that finds the lock held runs the demotion step on one shared 32-bit
// compare and subtract unit, one quotient step per cycle, until the top level
// in use or a remainder below the quantum stops it, then scans the levels and
// either frees the lock or reads the waiting thread from the FIFO memory. A
// release on a free lock returns an error. A finished result waits in an
// output register, and the next request is taken meanwhile.
module mlfq_lock_arbiter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  mlfq_pkg::req_item_t                 req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output mlfq_pkg::rsp_item_t                 rsp,
    input  logic                                cfg_we,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mlfq_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACQ   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_GRANT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;

    logic [mlfq_pkg::NLVL_W-1:0] levels_reg;
    logic [mlfq_pkg::HOLD_W-1:0] quantum_reg;

    logic                        lock_held_reg, lock_held_next;
    logic [mlfq_pkg::LVL_W-1:0]  lvl_tab_reg [mlfq_pkg::MAX_THREADS];
    logic [mlfq_pkg::TID_W-1:0]  head_reg  [mlfq_pkg::NUM_LEVELS];
    logic [mlfq_pkg::TID_W-1:0]  tail_reg  [mlfq_pkg::NUM_LEVELS];
    logic [mlfq_pkg::CNT_W-1:0]  count_reg [mlfq_pkg::NUM_LEVELS];

    logic [mlfq_pkg::TID_W-1:0]  fifo_mem [mlfq_pkg::NUM_LEVELS * mlfq_pkg::MAX_THREADS];
    logic [mlfq_pkg::TID_W-1:0]  rd_data_reg;
    logic [mlfq_pkg::ADDR_W-1:0] rd_addr;
    logic [mlfq_pkg::ADDR_W-1:0] wr_addr;
    logic                        wr_en;

    logic                        op_reg, op_next;
    logic [mlfq_pkg::TID_W-1:0]  tid_reg, tid_next;
    logic [mlfq_pkg::LVL_W-1:0]  lvl_reg, lvl_next;
    logic [mlfq_pkg::HOLD_W-1:0] rem_reg, rem_next;
    logic [mlfq_pkg::LVL_W-1:0]  cnt_reg, cnt_next;
    logic [mlfq_pkg::LVL_W-1:0]  lim_reg, lim_next;
    logic [mlfq_pkg::LVL_W-1:0]  base_reg, base_next;
    logic [mlfq_pkg::LVL_W-1:0]  nl_reg, nl_next;
    mlfq_pkg::rsp_item_t         res_reg, res_next;

    logic                        rsp_valid_reg;
    mlfq_pkg::rsp_item_t         rsp_reg;

    logic [mlfq_pkg::NLVL_W-1:0] levels_eff;
    logic [mlfq_pkg::LVL_W-1:0]  top;
    logic [mlfq_pkg::HOLD_W-1:0] quantum_eff;
    logic [mlfq_pkg::LVL_W-1:0]  old_lvl;
    logic [mlfq_pkg::LVL_W-1:0]  acq_lvl;
    logic [mlfq_pkg::LVL_W-1:0]  new_lvl;
    logic                        div_done;
    logic                        any_waiter;
    logic [mlfq_pkg::LVL_W-1:0]  first_lvl;
    logic                        req_xfer;
    logic                        tab_we;
    logic                        enq, deq;

    assign req_ready = (state_reg == S_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        if (levels_reg == '0)
        begin
            levels_eff = mlfq_pkg::NLVL_W'(1);
        end
        else if (levels_reg > mlfq_pkg::NLVL_W'(mlfq_pkg::NUM_LEVELS))
        begin
            levels_eff = mlfq_pkg::NLVL_W'(mlfq_pkg::NUM_LEVELS);
        end
        else
        begin
            levels_eff = levels_reg;
        end
    end

    logic [mlfq_pkg::NLVL_W-1:0] top_wide;
    assign top_wide    = levels_eff - mlfq_pkg::NLVL_W'(1);
    assign top         = top_wide[mlfq_pkg::LVL_W-1:0];
    assign quantum_eff = (quantum_reg == '0) ? mlfq_pkg::HOLD_W'(1) : quantum_reg;
    assign old_lvl     = lvl_tab_reg[req.thread_id];
    assign acq_lvl     = (old_lvl > top) ? top : old_lvl;
    assign new_lvl     = base_reg + cnt_reg;
    assign div_done    = (cnt_reg == lim_reg) || (rem_reg < quantum_eff);

    // lowest nonempty level
    always_comb
    begin
        any_waiter = 1'b0;
        first_lvl  = '0;
        for (int i = mlfq_pkg::NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                any_waiter = 1'b1;
                first_lvl  = mlfq_pkg::LVL_W'(i);
            end
        end
    end

    assign rd_addr = {lvl_reg, head_reg[lvl_reg]};
    assign wr_addr = {lvl_reg, tail_reg[lvl_reg]};

    always_comb
    begin
        state_next     = state_reg;
        lock_held_next = lock_held_reg;
        op_next        = op_reg;
        tid_next       = tid_reg;
        lvl_next       = lvl_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        lim_next       = lim_reg;
        base_next      = base_reg;
        nl_next        = nl_reg;
        res_next       = res_reg;
        tab_we         = 1'b0;
        enq            = 1'b0;
        deq            = 1'b0;
        wr_en          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    op_next   = req.op;
                    tid_next  = req.thread_id;
                    lvl_next  = acq_lvl;
                    rem_next  = req.hold_ticks;
                    cnt_next  = '0;
                    base_next = (old_lvl >= top) ? top : old_lvl;
                    lim_next  = (old_lvl >= top) ? '0 : (top - old_lvl);
                    if (req.op == mlfq_pkg::OP_ACQUIRE)
                    begin
                        state_next = S_ACQ;
                    end
                    else if (!lock_held_reg)
                    begin
                        res_next   = '{status: mlfq_pkg::ST_ERROR, granted_thread: '0,
                                       level: '0};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_ACQ:
            begin
                if (!lock_held_reg)
                begin
                    lock_held_next = 1'b1;
                    res_next = '{status: mlfq_pkg::ST_ACQUIRED, granted_thread: tid_reg,
                                 level: lvl_reg};
                end
                else if (count_reg[lvl_reg] == mlfq_pkg::CNT_W'(mlfq_pkg::MAX_THREADS))
                begin
                    res_next = '{status: mlfq_pkg::ST_ERROR, granted_thread: '0,
                                 level: lvl_reg};
                end
                else
                begin
                    enq      = 1'b1;
                    wr_en    = 1'b1;
                    res_next = '{status: mlfq_pkg::ST_QUEUED, granted_thread: '0,
                                 level: lvl_reg};
                end
                state_next = S_DONE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    tab_we     = 1'b1;
                    nl_next    = new_lvl;
                    state_next = S_SCAN;
                end
                else
                begin
                    rem_next = rem_reg - quantum_eff;
                    cnt_next = cnt_reg + mlfq_pkg::LVL_W'(1);
                end
            end
            S_SCAN:
            begin
                if (any_waiter)
                begin
                    lvl_next   = first_lvl;
                    state_next = S_READ;
                end
                else
                begin
                    lock_held_next = 1'b0;
                    res_next = '{status: mlfq_pkg::ST_FREED, granted_thread: '0,
                                 level: nl_reg};
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                deq        = 1'b1;
                state_next = S_GRANT;
            end
            S_GRANT:
            begin
                res_next = '{status: mlfq_pkg::ST_HANDED, granted_thread: rd_data_reg,
                             level: nl_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lock_held_reg <= 1'b0;
            levels_reg    <= mlfq_pkg::LEVELS_RESET;
            quantum_reg   <= mlfq_pkg::QUANTUM_RESET;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < mlfq_pkg::MAX_THREADS; i++)
            begin
                lvl_tab_reg[i] <= '0;
            end
            for (int i = 0; i < mlfq_pkg::NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            lock_held_reg <= lock_held_next;
            if (cfg_we)
            begin
                if (cfg_index == mlfq_pkg::CFG_LEVELS_IN_USE)
                begin
                    levels_reg <= cfg_data[mlfq_pkg::NLVL_W-1:0];
                end
                else if (cfg_index == mlfq_pkg::CFG_QUANTUM_TICKS)
                begin
                    quantum_reg <= cfg_data[mlfq_pkg::HOLD_W-1:0];
                end
            end
            if (tab_we)
            begin
                lvl_tab_reg[tid_reg] <= new_lvl;
            end
            if (enq)
            begin
                tail_reg[lvl_reg]  <= tail_reg[lvl_reg] + mlfq_pkg::TID_W'(1);
                count_reg[lvl_reg] <= count_reg[lvl_reg] + mlfq_pkg::CNT_W'(1);
            end
            if (deq)
            begin
                head_reg[lvl_reg]  <= head_reg[lvl_reg] + mlfq_pkg::TID_W'(1);
                count_reg[lvl_reg] <= count_reg[lvl_reg] - mlfq_pkg::CNT_W'(1);
            end
            if (state_reg == S_DONE && (!rsp_valid_reg || rsp_ready))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        tid_reg  <= tid_next;
        lvl_reg  <= lvl_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        lim_reg  <= lim_next;
        base_reg <= base_next;
        nl_reg   <= nl_next;
        res_reg  <= res_next;
        if (state_reg == S_DONE && (!rsp_valid_reg || rsp_ready))
        begin
            rsp_reg <= res_reg;
        end
    end

    // level fifo storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fifo_mem[wr_addr] <= tid_reg;
        end
        rd_data_reg <= fifo_mem[rd_addr];
    end

    logic [mlfq_pkg::TID_W-1:0] occ;
    assign occ = tail_reg[lvl_reg] - head_reg[lvl_reg];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |->
        count_reg[lvl_reg] <= mlfq_pkg::CNT_W'(mlfq_pkg::MAX_THREADS))
        else $error("level fifo count above depth");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> occ == count_reg[lvl_reg][mlfq_pkg::TID_W-1:0])
        else $error("fifo pointers disagree with count");

    a_div_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg <= lim_reg)
        else $error("demotion step ran past level limit");

    a_read_grant: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg == S_GRANT)
        else $error("fifo read not followed by grant");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");

    a_op_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV || state_reg == S_SCAN) |-> op_reg == mlfq_pkg::OP_RELEASE)
        else $error("release path entered by acquire");

endmodule
